// ----- rtl/core/hpg_pkg.sv -----
// Shared constants, types and the prime base table for the Halton point generator.
// Used by hpg_divider, hpg_seq and halton_point_generator; depends on nothing.

package hpg_pkg;

  localparam int MAX_DIMS    = 22;
  localparam int PRIME_COUNT = 22;
  localparam int FRAC_BITS   = 32;
  localparam int DIM_W       = 5;
  localparam int IDX_W       = 32;
  localparam int VAL_W       = IDX_W + 1;
  localparam int BASE_W      = 7;
  localparam int DEN_W       = 40;
  localparam int REM_W       = DEN_W + 1;
  localparam int CHUNK       = 8;
  localparam int CHUNKS      = (VAL_W + CHUNK - 1) / CHUNK;
  localparam int DVD_W       = CHUNK * CHUNKS;
  localparam int STEP_W      = $clog2(FRAC_BITS);
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SEL = 1'd1;

  // Table 1 is table 0 moved up by one prime, so one list of 23 primes serves both.
  localparam logic [BASE_W-1:0] PRIMES [0:PRIME_COUNT] = '{
    7'd2,  7'd3,  7'd5,  7'd7,  7'd11, 7'd13, 7'd17, 7'd19,
    7'd23, 7'd29, 7'd31, 7'd37, 7'd41, 7'd43, 7'd47, 7'd53,
    7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83
  };

  typedef struct packed {
    logic             frac_mode;
    logic [CHUNK-1:0] bits;
  } div_ctl_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] coord;
    logic [DIM_W-1:0]     dim;
    logic                 last;
  } res_t;

  function automatic logic [BASE_W-1:0] prime_base(input logic sel,
                                                   input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] idx;
    idx = dim + {{(DIM_W-1){1'b0}}, sel};
    if (idx > DIM_W'(PRIME_COUNT)) begin
      return PRIMES[0];
    end
    return PRIMES[idx];
  endfunction

endpackage

// ----- rtl/core/hpg_divider.sv -----
// Shared restoring-division step unit: eight radix-2 steps by a small base,
// or one fraction step by a wide denominator. Depends on hpg_pkg.

module hpg_divider import hpg_pkg::*; (
  input  div_ctl_t          ctl,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [DEN_W-1:0]  divisor_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [CHUNK-1:0]  q_o
);

  logic [BASE_W-1:0] r;
  logic [BASE_W:0]   r_sh;
  logic [REM_W-1:0]  f_sh;

  always_comb begin
    r    = rem_i[BASE_W-1:0];
    r_sh = '0;
    q_o  = '0;
    f_sh = {rem_i[REM_W-2:0], 1'b0};
    if (ctl.frac_mode) begin
      // The remainder stays below the denominator, so the shift never drops a bit.
      if (f_sh >= {1'b0, divisor_i}) begin
        rem_o  = f_sh - {1'b0, divisor_i};
        q_o[0] = 1'b1;
      end else begin
        rem_o = f_sh;
      end
    end else begin
      for (int i = CHUNK - 1; i >= 0; i--) begin
        r_sh = {r, ctl.bits[i]};
        if (r_sh >= {1'b0, divisor_i[BASE_W-1:0]}) begin
          r_sh   = r_sh - {1'b0, divisor_i[BASE_W-1:0]};
          q_o[i] = 1'b1;
        end
        r = r_sh[BASE_W-1:0];
      end
      rem_o = {{(REM_W-BASE_W){1'b0}}, r};
    end
  end

endmodule

// ----- rtl/core/hpg_seq.sv -----
// Sequencer and datapath registers for digit reversal and fraction division.
// Depends on hpg_pkg and hpg_divider.

module hpg_seq import hpg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IDX_W-1:0] point_index,
  input  logic [DIM_W-1:0] count,
  input  logic             sel,
  input  logic             res_ready,
  output logic             idle,
  output logic             res_valid,
  output res_t             res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FRAC = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [VAL_W-1:0]     point_r;
  logic [DIM_W-1:0]     count_r;
  logic                 sel_r;
  logic [DIM_W-1:0]     dim_r;
  logic [BASE_W-1:0]    base_r;
  logic [DVD_W-1:0]     val_r;
  logic [REM_W-1:0]     rem_r;
  logic [DEN_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [STEP_W-1:0]    step_r;

  div_ctl_t                div_ctl;
  logic [DEN_W-1:0]        div_divisor;
  logic [REM_W-1:0]        div_rem;
  logic [CHUNK-1:0]        div_q;
  logic [DEN_W+BASE_W-1:0] num_prod;
  logic [DEN_W+BASE_W-1:0] den_prod;
  logic [DEN_W-1:0]        num_new;

  assign div_ctl.frac_mode = (state_r == S_FRAC);
  assign div_ctl.bits      = val_r[DVD_W-1 -: CHUNK];
  assign div_divisor       = (state_r == S_FRAC) ? den_r
                                                 : {{(DEN_W-BASE_W){1'b0}}, base_r};

  hpg_divider u_div (
    .ctl       (div_ctl),
    .rem_i     (rem_r),
    .divisor_i (div_divisor),
    .rem_o     (div_rem),
    .q_o       (div_q)
  );

  assign num_prod = num_r * base_r;
  assign den_prod = den_r * base_r;
  assign num_new  = num_prod[DEN_W-1:0] + {{(DEN_W-BASE_W){1'b0}}, rem_r[BASE_W-1:0]};

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res.coord = frac_r;
  assign res.dim   = dim_r;
  assign res.last  = (dim_r == count_r - DIM_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (step_r == STEP_W'(CHUNKS - 1)) state_nxt = S_ACC;
      S_ACC:  state_nxt = (val_r == '0) ? S_FRAC : S_DIV;
      S_FRAC: if (step_r == STEP_W'(FRAC_BITS - 1)) state_nxt = S_EMIT;
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = res.last ? S_IDLE : S_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          point_r <= {1'b0, point_index} + VAL_W'(1);
          count_r <= count;
          sel_r   <= sel;
          dim_r   <= '0;
        end
      end
      S_LOAD: begin
        base_r <= prime_base(sel_r, dim_r);
        val_r  <= {{(DVD_W-VAL_W){1'b0}}, point_r};
        rem_r  <= '0;
        num_r  <= '0;
        den_r  <= DEN_W'(1);
        step_r <= '0;
      end
      S_DIV: begin
        // After the last chunk val_r holds the quotient and rem_r the digit.
        rem_r  <= div_rem;
        val_r  <= {val_r[DVD_W-CHUNK-1:0], div_q};
        step_r <= step_r + STEP_W'(1);
      end
      S_ACC: begin
        num_r  <= num_new;
        den_r  <= den_prod[DEN_W-1:0];
        step_r <= '0;
        rem_r  <= (val_r == '0) ? {1'b0, num_new} : '0;
      end
      S_FRAC: begin
        rem_r  <= div_rem;
        frac_r <= {frac_r[FRAC_BITS-2:0], div_q[0]};
        step_r <= step_r + STEP_W'(1);
      end
      S_EMIT: begin
        if (res_ready && !res.last) begin
          dim_r <= dim_r + DIM_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/halton_point_generator.sv -----
// Top level of the Halton point generator: configuration registers, output register
// and the digit-reversal sequencer. Depends on hpg_pkg and hpg_seq.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_point_index
//   out     | output    | out_valid / out_ready| out_coordinate, out_dimension_number,
//           |           |                      | out_last_of_point
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// For each dimension of a point, the sequencer loads the base, then for each base-b
// digit of index+1 passes the dividend through the shared divider (eight quotient
// bits per cycle) and accumulates the digit, then forms the fraction one bit a cycle.
// in_ready is high only while the sequencer is idle. A stalled out_ready holds the
// sequencer at its finished coordinate; the output register lets the last coordinate
// wait while the next point is taken. Reset is synchronous and needs no clearing pass.

module halton_point_generator import hpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IDX_W-1:0]     in_point_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS-1:0] out_coordinate,
  output logic [DIM_W-1:0]     out_dimension_number,
  output logic                 out_last_of_point,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] dim_count_r;
  logic             table_sel_r;
  logic             out_valid_r;
  res_t             out_r;

  logic [DIM_W-1:0] count_eff;
  logic             seq_idle;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  // A zero count still yields one coordinate; counts past the table saturate.
  always_comb begin
    if (dim_count_r == '0) begin
      count_eff = DIM_W'(1);
    end else if (dim_count_r > DIM_W'(MAX_DIMS)) begin
      count_eff = DIM_W'(MAX_DIMS);
    end else begin
      count_eff = dim_count_r;
    end
  end

  assign in_ready  = seq_idle;
  assign res_ready = !out_valid_r || out_ready;

  hpg_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid && seq_idle),
    .point_index (in_point_index),
    .count       (count_eff),
    .sel         (table_sel_r),
    .res_ready   (res_ready),
    .idle        (seq_idle),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DIM_W'(2);
      table_sel_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_COUNT: dim_count_r <= cfg_data[DIM_W-1:0];
        REG_TABLE_SEL: table_sel_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_coordinate       = out_r.coord;
  assign out_dimension_number = out_r.dim;
  assign out_last_of_point    = out_r.last;

endmodule
